// ===== rtl/vlr_pkg.sv =====
package vlr_pkg;

   localparam int STORE_BYTES = 4096;
   localparam int LINE_SLOTS  = 512;
   localparam int LEN_W       = 12;

   localparam int AW = $clog2(STORE_BYTES);
   localparam int SW = $clog2(LINE_SLOTS);
   // wide enough for line_len+1 and for any offset below twice the store size
   localparam int NW = (LEN_W + 1 > AW + 1) ? LEN_W + 1 : AW + 1;
   localparam int GW = $clog2(LINE_SLOTS + 2);

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_EMPTY    = 2'd1;
   localparam logic [1:0] STAT_TOO_LONG = 2'd2;
   localparam logic [1:0] STAT_SKIPPED  = 2'd3;

   localparam logic CSR_IDX_ENABLE = 1'b0;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_EV_CHECK,
      S_POP,
      S_POP_LOAD,
      S_PLACE,
      S_WBYTE,
      S_WTERM,
      S_RD_CHECK,
      S_RESP
   } state_type;

   // value below 2*STORE_BYTES folded into the store
   function automatic logic [AW-1:0] wrap_addr(input logic [NW-1:0] x);
      logic [NW-1:0] y;
      y = (x >= NW'(STORE_BYTES)) ? x - NW'(STORE_BYTES) : x;
      return AW'(y);
   endfunction

   function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
      return (s == SW'(LINE_SLOTS - 1)) ? '0 : s + SW'(1);
   endfunction

endpackage

// ===== rtl/variable_line_ring_evict_oldest.sv =====
// Each item passes decode and ends in the response state, which raises the result strobe. A skipped,
// empty, clear or unknown item goes straight there; a write item writes its byte (and the terminator
// after a last item); a placed first write item first pops the oldest lines while it lacks room or a
// free slot (a pop loads the next line start unless it empties the ring), then places the line; a read
// returns a byte or pops its line (at once if storing is disabled). busy drops the cycle after the strobe.
// Synchronous active-high reset empties the ring and disables storing; receiver cannot stall.
module variable_line_ring_evict_oldest
   import vlr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_type,
   input  logic [7:0]       req_data_byte,
   input  logic [LEN_W-1:0] req_line_len,
   input  logic             req_first_of_line,
   input  logic             req_last_of_line,
   input  logic             req_prompt_valid,
   output logic             rsp_valid,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_end_of_line,
   output logic [1:0]       rsp_status,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [7:0]    byte_store [STORE_BYTES];
   logic [AW-1:0] line_start_table [LINE_SLOTS];

   state_type state_ff, state_in;

   logic             enable_ff;
   logic [1:0]       req_type_ff, req_type_in;
   logic [7:0]       data_ff, data_in;
   logic [LEN_W-1:0] llen_ff, llen_in;
   logic             first_ff, first_in;
   logic             last_ff, last_in;
   logic             prompt_ff, prompt_in;

   logic [AW-1:0] data_head_ff, data_head_in;
   logic [AW-1:0] data_tail_ff, data_tail_in;
   logic [SW-1:0] slot_head_ff, slot_head_in;
   logic [SW-1:0] slot_tail_ff, slot_tail_in;
   logic [AW-1:0] read_cursor_ff, read_cursor_in;
   logic [NW-1:0] write_cursor_ff, write_cursor_in;
   logic [NW-1:0] write_end_ff, write_end_in;
   logic          accepted_ff, accepted_in;
   logic [GW-1:0] guard_ff, guard_in;

   logic [7:0] res_byte_ff, res_byte_in;
   logic       res_bv_ff, res_bv_in;
   logic       res_eol_ff, res_eol_in;
   logic [1:0] res_status_ff, res_status_in;

   logic          store_we;
   logic [AW-1:0] store_waddr, store_raddr;
   logic [7:0]    store_wdata, store_rdata_ff;
   logic          table_we;
   logic [AW-1:0] table_wdata, table_rdata_ff;
   logic [SW-1:0] table_raddr;

   logic          ring_empty, slots_full, too_long, evict_more, do_pop, ring_clear;
   logic          is_evict, write_skip;
   logic [SW-1:0] nxt;
   logic [AW-1:0] room, dst;
   logic [NW-1:0] need, place_sum;

   // ---------------- configuration port
   logic cfg_wr;
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == CSR_IDX_ENABLE) ? {31'b0, enable_ff} : 32'b0;

   // ---------------- shared terms
   assign ring_empty = (slot_head_ff == slot_tail_ff);
   assign slots_full = (slot_tail_ff == ((slot_head_ff != '0) ? slot_head_ff - SW'(1)
                                                               : SW'(LINE_SLOTS - 1)));
   assign need       = NW'(llen_ff) + NW'(1);
   assign too_long   = (need >= NW'(STORE_BYTES));
   assign nxt        = next_slot(slot_head_ff);
   assign is_evict   = (req_type_ff == REQ_WRITE);
   assign write_skip = !enable_ff || prompt_ff || too_long;

   always_comb begin
      if (data_head_ff > data_tail_ff) begin
         room = data_head_ff - data_tail_ff - AW'(1);
      end else if (data_head_ff == '0) begin
         room = AW'(STORE_BYTES - 1) - data_tail_ff;
      end else if (data_head_ff - AW'(1) > AW'(STORE_BYTES - 1) - data_tail_ff) begin
         room = data_head_ff - AW'(1);
      end else begin
         room = AW'(STORE_BYTES - 1) - data_tail_ff;
      end
   end

   assign evict_more = slots_full || (NW'(room) < need);
   assign do_pop     = evict_more && (guard_ff <= GW'(LINE_SLOTS)) && !ring_empty;

   // line goes at the tail unless it would not fit before the end of the store
   assign dst = ((data_head_ff >= data_tail_ff) ||
                 (NW'(STORE_BYTES) - NW'(data_tail_ff) > need)) ? data_tail_ff : '0;
   assign place_sum = NW'(dst) + need;

   assign store_raddr = wrap_addr(NW'(data_head_ff) + NW'(read_cursor_ff));
   assign table_raddr = nxt;

   // ---------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (req_type_ff)
               REQ_WRITE: begin
                  if (first_ff) state_in = write_skip ? S_RESP : S_EV_CHECK;
                  else          state_in = accepted_ff ? S_WBYTE : S_RESP;
               end
               REQ_READ: begin
                  if (ring_empty)      state_in = S_RESP;
                  else if (!enable_ff) state_in = S_POP;
                  else                 state_in = S_RD_CHECK;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_EV_CHECK: state_in = do_pop ? S_POP : S_PLACE;
         S_POP: begin
            if (nxt != slot_tail_ff)  state_in = S_POP_LOAD;
            else if (is_evict)        state_in = S_EV_CHECK;
            else                      state_in = S_RESP;
         end
         S_POP_LOAD: state_in = is_evict ? S_EV_CHECK : S_RESP;
         S_PLACE:    state_in = S_WBYTE;
         S_WBYTE:    state_in = (accepted_ff && last_ff) ? S_WTERM : S_RESP;
         S_WTERM:    state_in = S_RESP;
         S_RD_CHECK: begin
            if (store_rdata_ff == 8'd0 || read_cursor_ff == AW'(STORE_BYTES - 1)) begin
               state_in = S_POP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // ---------------- datapath and memory controls
   always_comb begin
      req_type_in     = req_type_ff;
      data_in         = data_ff;
      llen_in         = llen_ff;
      first_in        = first_ff;
      last_in         = last_ff;
      prompt_in       = prompt_ff;
      data_head_in    = data_head_ff;
      data_tail_in    = data_tail_ff;
      slot_head_in    = slot_head_ff;
      slot_tail_in    = slot_tail_ff;
      read_cursor_in  = read_cursor_ff;
      write_cursor_in = write_cursor_ff;
      write_end_in    = write_end_ff;
      accepted_in     = accepted_ff;
      guard_in        = guard_ff;
      res_byte_in     = res_byte_ff;
      res_bv_in       = res_bv_ff;
      res_eol_in      = res_eol_ff;
      res_status_in   = res_status_ff;
      store_we        = 1'b0;
      store_waddr     = wrap_addr(write_cursor_ff);
      store_wdata     = 8'd0;
      table_we        = 1'b0;
      table_wdata     = dst;
      ring_clear      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_type_in = req_type;
               data_in     = req_data_byte;
               llen_in     = req_line_len;
               first_in    = req_first_of_line;
               last_in     = req_last_of_line;
               prompt_in   = req_prompt_valid;
            end
         end
         S_DECODE: begin
            res_byte_in   = 8'd0;
            res_bv_in     = 1'b0;
            res_eol_in    = 1'b0;
            res_status_in = STAT_OK;
            guard_in      = '0;
            case (req_type_ff)
               REQ_WRITE: begin
                  if (first_ff) begin
                     accepted_in = 1'b0;
                     if (!enable_ff || prompt_ff) res_status_in = STAT_SKIPPED;
                     else if (too_long)           res_status_in = STAT_TOO_LONG;
                  end else if (!accepted_ff) begin
                     res_status_in = STAT_SKIPPED;
                  end
               end
               REQ_READ: begin
                  if (ring_empty) begin
                     res_status_in = STAT_EMPTY;
                  end else if (!enable_ff) begin
                     res_eol_in    = 1'b1;
                     res_status_in = STAT_EMPTY;
                  end
               end
               REQ_CLEAR: ring_clear = 1'b1;
               default: ;
            endcase
         end
         S_EV_CHECK: ;
         S_POP: begin
            guard_in = guard_ff + GW'(1);
            if (nxt == slot_tail_ff) ring_clear = 1'b1;
         end
         S_POP_LOAD: begin
            data_head_in   = table_rdata_ff;
            slot_head_in   = nxt;
            read_cursor_in = '0;
         end
         S_PLACE: begin
            table_we        = 1'b1;
            write_cursor_in = NW'(dst);
            write_end_in    = NW'(dst) + NW'(llen_ff);
            store_we        = 1'b1;
            store_waddr     = wrap_addr(NW'(dst) + NW'(llen_ff));
            store_wdata     = 8'd0;
            data_tail_in    = (place_sum >= NW'(STORE_BYTES)) ? '0 : AW'(place_sum);
            slot_tail_in    = next_slot(slot_tail_ff);
            accepted_in     = 1'b1;
         end
         S_WBYTE: begin
            if (accepted_ff && write_cursor_ff < write_end_ff) begin
               store_we        = 1'b1;
               store_wdata     = data_ff;
               write_cursor_in = write_cursor_ff + NW'(1);
            end
         end
         S_WTERM: begin
            store_we    = 1'b1;
            store_wdata = 8'd0;
            accepted_in = 1'b0;
         end
         S_RD_CHECK: begin
            if (store_rdata_ff == 8'd0 || read_cursor_ff == AW'(STORE_BYTES - 1)) begin
               res_eol_in = 1'b1;
            end else begin
               res_byte_in    = store_rdata_ff;
               res_bv_in      = 1'b1;
               read_cursor_in = read_cursor_ff + AW'(1);
            end
         end
         S_RESP: ;
         default: ;
      endcase

      if (ring_clear) begin
         data_head_in   = '0;
         data_tail_in   = '0;
         slot_head_in   = '0;
         slot_tail_in   = '0;
         read_cursor_in = '0;
         accepted_in    = 1'b0;
      end
   end

   // ---------------- memories
   always_ff @(posedge clock) begin
      if (store_we) byte_store[store_waddr] <= store_wdata;
      store_rdata_ff <= byte_store[store_raddr];
   end

   always_ff @(posedge clock) begin
      if (table_we) line_start_table[slot_tail_ff] <= table_wdata;
      table_rdata_ff <= line_start_table[table_raddr];
   end

   // ---------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         enable_ff       <= 1'b0;
         data_head_ff    <= '0;
         data_tail_ff    <= '0;
         slot_head_ff    <= '0;
         slot_tail_ff    <= '0;
         read_cursor_ff  <= '0;
         write_cursor_ff <= '0;
         write_end_ff    <= '0;
         accepted_ff     <= 1'b0;
         guard_ff        <= '0;
      end else begin
         state_ff        <= state_in;
         if (cfg_wr && paddr[2] == CSR_IDX_ENABLE) enable_ff <= pwdata[0];
         data_head_ff    <= data_head_in;
         data_tail_ff    <= data_tail_in;
         slot_head_ff    <= slot_head_in;
         slot_tail_ff    <= slot_tail_in;
         read_cursor_ff  <= read_cursor_in;
         write_cursor_ff <= write_cursor_in;
         write_end_ff    <= write_end_in;
         accepted_ff     <= accepted_in;
         guard_ff        <= guard_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      data_ff       <= data_in;
      llen_ff       <= llen_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      prompt_ff     <= prompt_in;
      res_byte_ff   <= res_byte_in;
      res_bv_ff     <= res_bv_in;
      res_eol_ff    <= res_eol_in;
      res_status_ff <= res_status_in;
   end

   // ---------------- outputs
   always_comb begin
      busy            = (state_ff != S_IDLE);
      rsp_valid       = (state_ff == S_RESP);
      rsp_out_byte    = res_byte_ff;
      rsp_byte_valid  = res_bv_ff;
      rsp_end_of_line = res_eol_ff;
      rsp_status      = res_status_ff;
   end

endmodule
